[hw/rtl/periodic_task_tick_scheduler_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the periodic task tick scheduler
// Concurrent checks share one clock and one active-high reset.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PTTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PTTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/ptts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_pkg
// Types and constants shared by the periodic task tick scheduler.
// ----------------------------------------------------------------------------
package ptts_pkg;

   localparam int ENTRIES     = 8;
   localparam int COUNT_BITS  = 16;
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int FIRED_W     = 3;
   localparam int STEP_W      = 8;
   localparam int FCNT_W      = $clog2(MAX_RESULTS + 1);

   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   localparam logic [STEP_W-1:0] TICK_STEP_RESET = STEP_W'(1);

   typedef struct packed {
      logic                  cmd;
      logic [2:0]            entry_index;
      logic [15:0]           first_delay;
      logic [15:0]           period_ms;
      logic                  enable;
   } req_type;

   typedef struct packed {
      logic [FIRED_W-1:0]    fired_index;
      logic                  fired;
      logic                  last;
   } rsp_type;

   typedef struct packed {
      logic                  enabled;
      logic [COUNT_BITS-1:0] period;
      logic [COUNT_BITS-1:0] remaining;
   } entry_type;

   typedef struct packed {
      logic                  en;
      logic [IDX_W-1:0]      addr;
      entry_type             entry;
   } tbl_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_FLUSH = 3'b100
   } state_type;

endpackage

[hw/rtl/ptts_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptts_table
// Task entry memory: one write port, one registered read port. Per-entry
// valid bits make unwritten entries read as disabled with zero times.
// ----------------------------------------------------------------------------
module ptts_table
   import ptts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_addr,
   output entry_type        rd_entry,
   input  tbl_wr_type       wr
);

   entry_type              mem [ENTRIES];
   logic [ENTRIES-1:0]     valid_ff;
   entry_type              rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.entry;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // never-written entries read as the reset value
   assign rd_entry = rd_valid_ff ? rd_data_ff : '0;

endmodule

[hw/rtl/periodic_task_tick_scheduler.sv]
`timescale 1ns / 1ps
// Load: acknowledge registered in the cycle after acceptance; one load per cycle
//   when the output is not stalled. Tick: walks the table one entry per cycle
//   (read, modify, write back) unless held; new requests wait until flush ends.
// Output stall holds the walk while a firing waits for the output register.
// Reset: tick_step returns to 1; per-entry valid bits clear at once, so every
//   entry reads disabled with zero times and no clearing pass is needed.
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler
// Time-triggered cooperative scheduler table with load and tick commands.
// ----------------------------------------------------------------------------
`include "periodic_task_tick_scheduler_defines.svh"

module periodic_task_tick_scheduler
   import ptts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [STEP_W-1:0] csr_wr_data
);

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 held_valid_ff, held_valid_in;
   logic [FIRED_W-1:0]   held_idx_ff, held_idx_in;
   logic [FCNT_W-1:0]    fire_cnt_ff, fire_cnt_in;
   logic [STEP_W-1:0]    tick_step_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 slot_free;
   logic                 req_accept;
   logic [IDX_W-1:0]     rd_addr;
   entry_type            cur;
   tbl_wr_type           wr;
   logic                 fire;
   logic                 report;
   logic                 step_go;
   logic                 push;
   rsp_type              push_data;
   logic [COUNT_BITS-1:0] base;

   ptts_table u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (cur),
      .wr       (wr)
   );

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) && slot_free);
   assign req_accept = req_valid && !req_stall;

   // entry evaluation for the walk
   assign fire    = cur.enabled && (cur.remaining == '0);
   assign report  = fire && (fire_cnt_ff < FCNT_W'(MAX_RESULTS));
   assign step_go = !(report && held_valid_ff) || slot_free;
   assign base    = fire ? cur.period : cur.remaining;

   always_comb begin
      state_in      = state_ff;
      eval_idx_in   = eval_idx_ff;
      held_valid_in = held_valid_ff;
      held_idx_in   = held_idx_ff;
      fire_cnt_in   = fire_cnt_ff;
      rd_addr       = '0;
      wr            = '0;
      push          = 1'b0;
      push_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_data.cmd == CMD_LOAD) begin
                  if (32'(req_data.entry_index) < 32'(ENTRIES)) begin
                     wr.en              = 1'b1;
                     wr.addr            = IDX_W'(req_data.entry_index);
                     wr.entry.enabled   = req_data.enable;
                     wr.entry.period    = COUNT_BITS'(req_data.period_ms);
                     wr.entry.remaining = COUNT_BITS'(req_data.first_delay);
                  end
                  push           = 1'b1;
                  push_data.last = 1'b1;
               end else begin
                  state_in      = ST_WALK;
                  eval_idx_in   = '0;
                  held_valid_in = 1'b0;
                  fire_cnt_in   = '0;
               end
            end
         end
         ST_WALK: begin
            if (step_go) begin
               wr.en              = 1'b1;
               wr.addr            = eval_idx_ff;
               wr.entry.enabled   = cur.enabled;
               wr.entry.period    = cur.period;
               wr.entry.remaining = base - COUNT_BITS'(tick_step_ff);
               if (report) begin
                  // release the previous firing, keep this one for the last flag
                  if (held_valid_ff) begin
                     push                  = 1'b1;
                     push_data.fired_index = held_idx_ff;
                     push_data.fired       = 1'b1;
                  end
                  held_valid_in = 1'b1;
                  held_idx_in   = FIRED_W'(eval_idx_ff);
                  fire_cnt_in   = fire_cnt_ff + FCNT_W'(1);
               end
               rd_addr     = IDX_W'(eval_idx_ff + IDX_W'(1));
               eval_idx_in = IDX_W'(eval_idx_ff + IDX_W'(1));
               if (eval_idx_ff == IDX_W'(ENTRIES - 1)) begin
                  state_in = ST_FLUSH;
               end
            end else begin
               // hold: re-read the same entry
               rd_addr = eval_idx_ff;
            end
         end
         ST_FLUSH: begin
            if (slot_free) begin
               push                  = 1'b1;
               push_data.fired_index = held_valid_ff ? held_idx_ff : '0;
               push_data.fired       = held_valid_ff;
               push_data.last        = 1'b1;
               held_valid_in         = 1'b0;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      priority if (push) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = push_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         eval_idx_ff   <= '0;
         held_valid_ff <= 1'b0;
         fire_cnt_ff   <= '0;
         tick_step_ff  <= TICK_STEP_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eval_idx_ff   <= eval_idx_in;
         held_valid_ff <= held_valid_in;
         fire_cnt_ff   <= fire_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            tick_step_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      held_idx_ff <= held_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `PTTS_ASSERT_NEXT(a_tick_starts_walk, clock, reset, req_accept && (req_data.cmd == CMD_TICK), (state_ff == ST_WALK) && (eval_idx_ff == '0), "tick did not start walk at entry zero")
   `PTTS_ASSERT_NEXT(a_load_acks, clock, reset, req_accept && (req_data.cmd == CMD_LOAD), rsp_valid_ff && rsp_data_ff.last && !rsp_data_ff.fired, "load not acknowledged")
   `PTTS_ASSERT_NOW(a_held_counted, clock, reset, held_valid_ff, fire_cnt_ff != '0, "held firing without count")

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives load and tick transactions into the scheduler table, keeps its own
// copy of every entry to work out which entries fire on each tick, and checks
// each response in order against that prediction.
// ----------------------------------------------------------------------------
module testbench;
   import ptts_pkg::*;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_type           rsp_data;
   logic              csr_wr_en;
   logic [STEP_W-1:0] csr_wr_data;

   // Shadow copy of the scheduler table and its step register
   logic [COUNT_BITS-1:0] shadow_remaining [ENTRIES];
   logic [COUNT_BITS-1:0] shadow_period [ENTRIES];
   logic                  shadow_armed [ENTRIES];
   logic [STEP_W-1:0]     shadow_step;

   rsp_type firing_queue [$];
   int      errors;
   bit      idling_on;
   int      stall_left;

   periodic_task_tick_scheduler uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Response-side backpressure in random bursts
   initial begin
      rsp_stall = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (!idling_on) begin
            stall_left = 0;
         end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         rsp_stall = (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   // Work out the responses of one accepted transaction
   function automatic void advance_schedule(input req_type item);
      rsp_type hits [MAX_RESULTS];
      int      count;
      count = 0;
      if (item.cmd == CMD_LOAD) begin
         shadow_remaining[item.entry_index] = item.first_delay;
         shadow_period[item.entry_index]    = item.period_ms;
         shadow_armed[item.entry_index]     = item.enable;
         firing_queue.push_back('{fired_index: '0, fired: 1'b0, last: 1'b1});
         return;
      end
      for (int i = 0; i < ENTRIES; i++) begin
         if (shadow_armed[i] && shadow_remaining[i] == '0) begin
            shadow_remaining[i] = shadow_period[i];
            if (count < MAX_RESULTS) begin
               hits[count] = '{fired_index: FIRED_W'(i), fired: 1'b1, last: 1'b0};
               count++;
            end
         end
         shadow_remaining[i] = shadow_remaining[i] - COUNT_BITS'(shadow_step);
      end
      if (count == 0) begin
         firing_queue.push_back('{fired_index: '0, fired: 1'b0, last: 1'b1});
      end else begin
         hits[count-1].last = 1'b1;
         for (int k = 0; k < count; k++) firing_queue.push_back(hits[k]);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (firing_queue.size() == 0) begin
            $display("%0t unexpected response: expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = firing_queue.pop_front();
            if (rsp_data.fired_index !== want.fired_index) begin
               $display("%0t fired_index mismatch: expected %0d, actual %0d",
                        $time, want.fired_index, rsp_data.fired_index);
               errors++;
            end
            if (rsp_data.fired !== want.fired) begin
               $display("%0t fired mismatch: expected %0b, actual %0b",
                        $time, want.fired, rsp_data.fired);
               errors++;
            end
            if (rsp_data.last !== want.last) begin
               $display("%0t last mismatch: expected %0b, actual %0b",
                        $time, want.last, rsp_data.last);
               errors++;
            end
         end
      end
   end

   function automatic req_type make_req(input logic cmd, input int idx, input int delay,
                                        input int period, input logic en);
      req_type item;
      item.cmd         = cmd;
      item.entry_index = 3'(idx);
      item.first_delay = 16'(delay);
      item.period_ms   = 16'(period);
      item.enable      = en;
      return item;
   endfunction

   task automatic issue(input req_type item);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      advance_schedule(item);
   endtask

   task automatic tick();
      issue(make_req(CMD_TICK, $urandom_range(0, 7), $urandom, $urandom, 1'($urandom)));
   endtask

   // Drop valid and hold until every predicted response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (firing_queue.size() != 0) @(posedge clock);
   endtask

   task automatic set_tick_step(input logic [STEP_W-1:0] value);
      wait_drained();
      repeat (ENTRIES + 3) @(posedge clock);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      shadow_step = value;
   endtask

   task automatic test_load_ack_and_empty_tick();
      issue(make_req(CMD_LOAD, 7, 0, 0, 1'b0));
      issue(make_req(CMD_LOAD, 0, 16'hffff, 16'hffff, 1'b1));
      tick();
   endtask

   task automatic test_full_table_firing();
      for (int i = 0; i < ENTRIES; i++) issue(make_req(CMD_LOAD, i, 0, 2, 1'b1));
      repeat (3) tick();
   endtask

   task automatic test_zero_tick_step();
      set_tick_step(8'd0);
      issue(make_req(CMD_LOAD, 3, 0, 0, 1'b1));
      repeat (2) tick();
   endtask

   task automatic test_max_step_wrap();
      set_tick_step(8'd255);
      issue(make_req(CMD_LOAD, 5, 255, 510, 1'b1));
      repeat (4) tick();
   endtask

   // Mostly ticks over entries loaded at multiples of the step, so that they
   // land on zero and refire; a share of loads carry arbitrary values.
   task automatic random_phase(input logic [STEP_W-1:0] step, input int count);
      int unit;
      set_tick_step(step);
      unit = int'(step);
      for (int n = 0; n < count; n++) begin
         if (n == count / 2 || $urandom_range(0, 39) == 0) wait_drained();
         if ($urandom_range(0, 9) < 7) begin
            tick();
         end else if ($urandom_range(0, 4) == 0) begin
            issue(make_req(CMD_LOAD, $urandom_range(0, 7), $urandom, $urandom,
                           1'($urandom)));
         end else begin
            issue(make_req(CMD_LOAD, $urandom_range(0, 7), unit * $urandom_range(0, 6),
                           unit * $urandom_range(1, 8), $urandom_range(0, 7) != 0));
         end
      end
   endtask

   task automatic test_random_traffic();
      random_phase(8'd1, 50);
      random_phase(8'd255, 50);
      random_phase(8'd2, 50);
      random_phase(8'($urandom_range(3, 254)), 50);
      idling_on = 1'b0;
      random_phase(8'd1, 50);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      errors      = 0;
      idling_on   = 1'b1;
      shadow_step = TICK_STEP_RESET;
      for (int i = 0; i < ENTRIES; i++) begin
         shadow_remaining[i] = '0;
         shadow_period[i]    = '0;
         shadow_armed[i]     = 1'b0;
      end
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_load_ack_and_empty_tick();
      test_full_table_firing();
      test_zero_tick_step();
      test_max_step_wrap();
      test_random_traffic();

      wait_drained();
      repeat (ENTRIES + 8) @(posedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ptts_pkg.sv
hw/rtl/ptts_table.sv
hw/rtl/periodic_task_tick_scheduler.sv
bench/testbench.sv
